[rtl/core/sacvb_pkg.sv]
// Package for the set-associative cache with victim buffer.
// Holds the controller states, register indexes, policy codes and the
// command and status structs shared by the controller and the datapath.
`timescale 1ns / 1ps
`default_nettype none

package sacvb_pkg;

  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int COUNT_W   = 32;
  localparam int STAMP_W   = 64;
  localparam int OUT_WAY_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CACHE_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VB_ENABLE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VB_ENTRIES = 3'd5;

  localparam logic [1:0] POL_LRU  = 2'd0;
  localparam logic [1:0] POL_LFU  = 2'd1;
  localparam logic [1:0] POL_FIFO = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic look;
    logic scan_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

[rtl/core/sacvb_if.sv]
// Request and response channel interfaces of the cache block.
// Both carry valid, ready and the payload; no package is needed.
`timescale 1ns / 1ps
`default_nettype none

interface sacvb_req_if #(parameter int ADDR_BITS = 48) ();
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] addr;
  logic                 is_store;
  modport source(output valid, addr, is_store, input ready);
  modport sink(input valid, addr, is_store, output ready);
endinterface

interface sacvb_rsp_if ();
  logic       valid;
  logic       ready;
  logic       l1_hit;
  logic       vc_hit;
  logic       l1_evict;
  logic       writeback;
  logic       mem_fetch;
  logic [2:0] way_used;
  modport source(output valid, l1_hit, vc_hit, l1_evict, writeback, mem_fetch, way_used,
                 input ready);
  modport sink(input valid, l1_hit, vc_hit, l1_evict, writeback, mem_fetch, way_used,
               output ready);
endinterface

`default_nettype wire

[rtl/core/sacvb_ctrl.sv]
// Controller state machine of the cache block.
// Depends on sacvb_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module sacvb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  sacvb_pkg::status_t    st,
  output sacvb_pkg::cmd_t       cmd
);

  sacvb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sacvb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      sacvb_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = sacvb_pkg::ST_LOOK;
        end
      end
      sacvb_pkg::ST_LOOK: begin
        cmd.look   = 1'b1;
        state_next = sacvb_pkg::ST_SCAN;
      end
      sacvb_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) begin
          state_next = sacvb_pkg::ST_COMMIT;
        end
      end
      sacvb_pkg::ST_COMMIT: begin
        if (!st.out_busy) begin
          cmd.commit = 1'b1;
          state_next = sacvb_pkg::ST_IDLE;
        end
      end
      default: state_next = sacvb_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/sacvb_dp.sv]
// Datapath of the cache block: configuration registers, set memory,
// victim buffer, replacement scan and the response register.
// Depends on sacvb_pkg for constants, codes and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module sacvb_dp #(
  parameter int MAX_SETS       = 256,
  parameter int MAX_WAYS       = 8,
  parameter int MAX_VB_ENTRIES = 8,
  parameter int ADDR_BITS      = 48
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [sacvb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sacvb_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic [ADDR_BITS-1:0]                in_addr,
  input  wire logic                                in_is_store,
  input  sacvb_pkg::cmd_t                          cmd,
  output sacvb_pkg::status_t                       st,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic                                     out_l1_hit,
  output logic                                     out_vc_hit,
  output logic                                     out_l1_evict,
  output logic                                     out_writeback,
  output logic                                     out_mem_fetch,
  output logic [sacvb_pkg::OUT_WAY_W-1:0]          out_way_used
);

  localparam int SET_BITS = $clog2(MAX_SETS + 1) - 1;
  localparam int SET_IW   = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int ROWS     = 1 << SET_BITS;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W     = $clog2(MAX_WAYS + 1);
  localparam int VB_W     = (MAX_VB_ENTRIES > 1) ? $clog2(MAX_VB_ENTRIES) : 1;
  localparam int NVB_W    = $clog2(MAX_VB_ENTRIES + 1);
  localparam int MAXN     = (MAX_WAYS > MAX_VB_ENTRIES) ? MAX_WAYS : MAX_VB_ENTRIES;
  localparam int CNT_W    = (MAXN > 1) ? $clog2(MAXN) : 1;
  localparam int EW       = CNT_W + 1;
  localparam int CW       = sacvb_pkg::COUNT_W;
  localparam int TW       = sacvb_pkg::STAMP_W;

  typedef struct packed {
    logic                 valid;
    logic                 dirty;
    logic [ADDR_BITS-1:0] tag;
    logic [CW-1:0]        use_count;
    logic [TW-1:0]        last_use;
    logic [TW-1:0]        inserted;
  } line_t;

  typedef struct packed {
    line_t [MAX_WAYS-1:0] lines;
    logic  [WAY_W-1:0]    mru;
  } row_t;

  // Configuration registers.
  logic [4:0] cache_size_log2;
  logic [3:0] block_size_log2;
  logic [1:0] ways_log2;
  logic [1:0] replace_policy;
  logic       victim_enable;
  logic [3:0] victim_entries;

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_size_log2 <= 5'd12;
      block_size_log2 <= 4'd5;
      ways_log2       <= 2'd2;
      replace_policy  <= sacvb_pkg::POL_LRU;
      victim_enable   <= 1'b0;
      victim_entries  <= 4'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        sacvb_pkg::REG_CACHE_SIZE: cache_size_log2 <= cfg_data[4:0];
        sacvb_pkg::REG_BLOCK_SIZE: block_size_log2 <= cfg_data[3:0];
        sacvb_pkg::REG_WAYS:       ways_log2       <= cfg_data[1:0];
        sacvb_pkg::REG_POLICY:     replace_policy  <= cfg_data[1:0];
        sacvb_pkg::REG_VB_ENABLE:  victim_enable   <= cfg_data[0];
        sacvb_pkg::REG_VB_ENTRIES: victim_entries  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Geometry derived from the configuration.
  logic [5:0]       bs_sum;
  logic [4:0]       idx_bits;
  logic [3:0]       nways_full;
  logic [NW_W-1:0]  nways;
  logic [NVB_W-1:0] nvb;

  always_comb begin
    bs_sum   = 6'(block_size_log2) + 6'(ways_log2);
    idx_bits = 5'd0;
    if (6'(cache_size_log2) >= bs_sum) begin
      idx_bits = 5'(6'(cache_size_log2) - bs_sum);
    end
    if (32'(idx_bits) > SET_BITS) begin
      idx_bits = 5'(SET_BITS);
    end
    nways_full = 4'd1 << ways_log2;
    nways = (32'(nways_full) > MAX_WAYS) ? NW_W'(MAX_WAYS) : NW_W'(nways_full);
    if (victim_entries == 4'd0) begin
      nvb = NVB_W'(1);
    end else if (32'(victim_entries) > MAX_VB_ENTRIES) begin
      nvb = NVB_W'(MAX_VB_ENTRIES);
    end else begin
      nvb = NVB_W'(victim_entries);
    end
  end

  // Request latch and address split.
  logic [ADDR_BITS-1:0] in_baddr, baddr_q, tag_q, set_mask;
  logic [SET_IW-1:0]    in_set, set_q;
  logic                 store_q;
  logic [TW-1:0]        access_clock;

  always_comb begin
    set_mask = (ADDR_BITS'(1) << idx_bits) - ADDR_BITS'(1);
    in_baddr = in_addr >> block_size_log2;
    in_set   = SET_IW'(in_baddr & set_mask);
    set_q    = SET_IW'(baddr_q & set_mask);
    tag_q    = baddr_q >> idx_bits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      access_clock <= '0;
    end else if (cmd.accept) begin
      access_clock <= access_clock + TW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      baddr_q <= in_baddr;
      store_q <= in_is_store;
    end
  end

  // Set memory; a row never written reads as all zero.
  row_t             mem [ROWS];
  row_t             row_raw, row, row_new;
  logic [ROWS-1:0]  row_init;
  logic             init_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      row_raw <= mem[in_set];
    end
    if (cmd.commit) begin
      mem[set_q] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
      init_q   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        init_q <= row_init[in_set];
      end
      if (cmd.commit) begin
        row_init[set_q] <= 1'b1;
      end
    end
  end

  assign row = init_q ? row_raw : '0;

  // Victim buffer.
  logic [ADDR_BITS-1:0] vb_addr [MAX_VB_ENTRIES];
  logic [MAX_VB_ENTRIES-1:0] vb_valid, vb_dirty;
  logic [TW-1:0]        vb_ins [MAX_VB_ENTRIES];

  // Lookup results.
  logic             hit_c, vhit_c, inv_c;
  logic [WAY_W-1:0] hit_way_c, inv_way_c;
  logic [VB_W-1:0]  vhit_e_c;
  logic             hit_q, vhit_q, inv_q, vhit_dirty_q;
  logic [WAY_W-1:0] hit_way_q, inv_way_q;
  logic [VB_W-1:0]  vhit_e_q;

  always_comb begin
    hit_c     = 1'b0;
    hit_way_c = '0;
    inv_c     = 1'b0;
    inv_way_c = '0;
    vhit_c    = 1'b0;
    vhit_e_c  = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (w < 32'(nways)) begin
        if (!hit_c && row.lines[w].valid && row.lines[w].tag == tag_q) begin
          hit_c     = 1'b1;
          hit_way_c = WAY_W'(w);
        end
        if (!inv_c && !row.lines[w].valid) begin
          inv_c     = 1'b1;
          inv_way_c = WAY_W'(w);
        end
      end
    end
    for (int e = 0; e < MAX_VB_ENTRIES; e++) begin
      if (e < 32'(nvb) && !vhit_c && vb_valid[e] && vb_addr[e] == baddr_q) begin
        vhit_c   = victim_enable;
        vhit_e_c = VB_W'(e);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      hit_q        <= hit_c;
      hit_way_q    <= hit_way_c;
      inv_q        <= inv_c;
      inv_way_q    <= inv_way_c;
      vhit_q       <= vhit_c;
      vhit_e_q     <= vhit_e_c;
      vhit_dirty_q <= vb_dirty[vhit_e_c];
    end
  end

  // Replacement scan: one way and one buffer entry per cycle.
  logic [CNT_W-1:0] cnt;
  logic [WAY_W-1:0] best_way, scan_way;
  logic [VB_W-1:0]  best_slot, scan_slot;
  logic [NW_W:0]    scan_steps;
  logic             way_better;
  line_t            line_w, line_b;

  always_comb begin
    scan_steps = (nways > NW_W'(nvb)) ? (NW_W+1)'(nways) : (NW_W+1)'(nvb);
    st.scan_last = (EW'(cnt) + EW'(1)) >= EW'(scan_steps);
    st.out_busy  = out_valid && !out_ready;
    scan_way  = cnt[WAY_W-1:0];
    scan_slot = cnt[VB_W-1:0];
    line_w    = row.lines[scan_way];
    line_b    = row.lines[best_way];
    case (replace_policy)
      sacvb_pkg::POL_LFU: begin
        way_better = (scan_way != row.mru) &&
                     ((line_w.use_count < line_b.use_count) ||
                      (line_w.use_count == line_b.use_count && line_w.tag > line_b.tag));
      end
      sacvb_pkg::POL_FIFO: way_better = line_w.inserted < line_b.inserted;
      default:             way_better = line_w.last_use < line_b.last_use;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      cnt       <= '0;
      best_slot <= '0;
      best_way  <= (replace_policy == sacvb_pkg::POL_LFU && row.mru == '0) ?
                   WAY_W'(1) : '0;
    end else if (cmd.scan_step) begin
      cnt <= cnt + CNT_W'(1);
      if (EW'(cnt) < EW'(nways) && way_better) begin
        best_way <= scan_way;
      end
      if (EW'(cnt) < EW'(nvb) && vb_ins[scan_slot] < vb_ins[best_slot]) begin
        best_slot <= scan_slot;
      end
    end
  end

  // Commit: update the row, the victim buffer and the response.
  logic [WAY_W-1:0]     pick, sel_way;
  line_t                sel_line, fill;
  logic                 slot_free;
  logic [VB_W-1:0]      free_slot, slot;
  logic                 vb_we, vb_wdirty, vb_wvalid;
  logic [VB_W-1:0]      vb_wi;
  logic [ADDR_BITS-1:0] vaddr;
  logic                 r_ev, r_wb;

  always_comb begin
    slot_free = 1'b0;
    free_slot = '0;
    for (int e = 0; e < MAX_VB_ENTRIES; e++) begin
      if (e < 32'(nvb) && !slot_free && !vb_valid[e]) begin
        slot_free = 1'b1;
        free_slot = VB_W'(e);
      end
    end
    slot = slot_free ? free_slot : best_slot;

    pick = (nways == NW_W'(1)) ? '0 : best_way;
    if (hit_q) begin
      sel_way = hit_way_q;
    end else if (vhit_q || !inv_q) begin
      sel_way = pick;
    end else begin
      sel_way = inv_way_q;
    end
    sel_line = row.lines[sel_way];
    vaddr    = (sel_line.tag << idx_bits) | ADDR_BITS'(set_q);

    fill.valid     = 1'b1;
    fill.dirty     = store_q | (vhit_q & vhit_dirty_q);
    fill.tag       = tag_q;
    fill.use_count = '0;
    fill.last_use  = access_clock;
    fill.inserted  = access_clock;

    row_new     = row;
    row_new.mru = sel_way;
    vb_we       = 1'b0;
    vb_wi       = slot;
    vb_wvalid   = 1'b1;
    vb_wdirty   = sel_line.dirty;
    r_ev        = 1'b0;
    r_wb        = 1'b0;

    if (hit_q) begin
      if (sel_line.use_count != '1) begin
        row_new.lines[sel_way].use_count = sel_line.use_count + CW'(1);
      end
      row_new.lines[sel_way].last_use = access_clock;
      row_new.lines[sel_way].dirty    = sel_line.dirty | store_q;
    end else begin
      row_new.lines[sel_way] = fill;
      if (vhit_q) begin
        r_ev      = sel_line.valid;
        vb_we     = 1'b1;
        vb_wi     = vhit_e_q;
        vb_wvalid = sel_line.valid;
      end else if (!inv_q) begin
        r_ev = 1'b1;
        if (victim_enable) begin
          vb_we = 1'b1;
          r_wb  = !slot_free && vb_dirty[slot];
        end else begin
          r_wb = sel_line.dirty;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb_valid <= '0;
      vb_dirty <= '0;
      for (int e = 0; e < MAX_VB_ENTRIES; e++) begin
        vb_ins[e] <= '0;
      end
    end else if (cmd.commit && vb_we) begin
      vb_valid[vb_wi] <= vb_wvalid;
      vb_dirty[vb_wi] <= vb_wdirty;
      vb_ins[vb_wi]   <= access_clock;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && vb_we) begin
      vb_addr[vb_wi] <= vaddr;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_l1_hit    <= hit_q;
      out_vc_hit    <= !hit_q && vhit_q;
      out_l1_evict  <= r_ev;
      out_writeback <= r_wb;
      out_mem_fetch <= !hit_q && !vhit_q;
      out_way_used  <= sacvb_pkg::OUT_WAY_W'(sel_way);
    end
  end

endmodule

`default_nettype wire

[rtl/core/set_assoc_cache_with_victim_buffer.sv]
// Top level of the set-associative cache tag model with a victim buffer.
// Depends on sacvb_pkg, sacvb_if, sacvb_ctrl and sacvb_dp.
//
// Usage: each request on req carries a byte address and a store flag; each
// request yields exactly one response on rsp with hit, victim hit, evict,
// writeback, fetch flags and the way used. Both channels are valid/ready.
// Configuration is written through cfg_we, cfg_index and cfg_data while the
// block is idle; writes to indexes beyond the register list are ignored.
// Sequence: a request accepted in IDLE is looked up in LOOK, then the
// replacement scan walks max(ways, victim entries) steps, one per cycle,
// and the response is registered in COMMIT. One request is in flight at a
// time and the next one is taken in the cycle after commit.
// The response register lets a new request be taken while a finished
// response still waits; if rsp stays stalled, the next request holds before
// commit until the response register is free.
// Reset clears valid state, the victim buffer and the access clock, and
// loads the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_with_victim_buffer #(
  parameter int MAX_SETS       = 256,
  parameter int MAX_WAYS       = 8,
  parameter int MAX_VB_ENTRIES = 8,
  parameter int ADDR_BITS      = 48
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [sacvb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sacvb_pkg::CFG_W-1:0]     cfg_data,
  sacvb_req_if.sink                            req,
  sacvb_rsp_if.source                          rsp
);

  sacvb_pkg::cmd_t    cmd;
  sacvb_pkg::status_t st;

  sacvb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  sacvb_dp #(
    .MAX_SETS       (MAX_SETS),
    .MAX_WAYS       (MAX_WAYS),
    .MAX_VB_ENTRIES (MAX_VB_ENTRIES),
    .ADDR_BITS      (ADDR_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_addr       (req.addr),
    .in_is_store   (req.is_store),
    .cmd           (cmd),
    .st            (st),
    .out_ready     (rsp.ready),
    .out_valid     (rsp.valid),
    .out_l1_hit    (rsp.l1_hit),
    .out_vc_hit    (rsp.vc_hit),
    .out_l1_evict  (rsp.l1_evict),
    .out_writeback (rsp.writeback),
    .out_mem_fetch (rsp.mem_fetch),
    .out_way_used  (rsp.way_used)
  );

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(rsp.valid && !rsp.ready))
    else $error("commit while the response register is still occupied");

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> $onehot({rsp.l1_hit, rsp.vc_hit, rsp.mem_fetch}))
    else $error("response must come from exactly one of L1, victim buffer or memory");

  a_hit_quiet: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.l1_hit) |-> (!rsp.l1_evict && !rsp.writeback))
    else $error("an L1 hit displaced or wrote back a block");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while another is in flight");

endmodule

`default_nettype wire

[tb/tb.sv]
// Testbench for the set-associative cache tag model with a victim buffer.
// A scoreboard class predicts hit, victim hit, evict, writeback, fetch and way
// for every request and checks each response; depends on sacvb_pkg and sacvb_if.
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] POL_SPARE = 2'd3;
  localparam int NUM_PHASES = 9;
  localparam int PHASE_ITEMS = 205;

  typedef struct packed {
    logic       l1_hit;
    logic       vc_hit;
    logic       l1_evict;
    logic       writeback;
    logic       mem_fetch;
    logic [2:0] way_used;
  } access_result_t;

  class cache_scoreboard;
    bit [47:0] line_tag [2048];
    bit        line_valid [2048];
    bit        line_dirty [2048];
    bit        line_written [2048];
    bit [31:0] line_uses [2048];
    bit [63:0] line_last [2048];
    bit [63:0] line_born [2048];
    bit [2:0]  set_mru [256];
    bit [47:0] vb_addr [8];
    bit        vb_valid [8];
    bit        vb_dirty [8];
    bit [63:0] vb_born [8];
    bit [63:0] stamp;
    int unsigned c_log2 = 12, b_log2 = 5, s_log2 = 2, vb_count = 2;
    bit [1:0]  policy = sacvb_pkg::POL_LRU;
    bit        vb_on = 0;
    access_result_t expected_results[$];
    int errors, checked, vb_hits, l1_hits, wbacks;

    function void set_reg(logic [sacvb_pkg::CFG_IDX_W-1:0] idx,
                          logic [sacvb_pkg::CFG_W-1:0] v);
      case (idx)
        sacvb_pkg::REG_CACHE_SIZE: c_log2 = v;
        sacvb_pkg::REG_BLOCK_SIZE: b_log2 = v[3:0];
        sacvb_pkg::REG_WAYS:       s_log2 = v[1:0];
        sacvb_pkg::REG_POLICY:     policy = v[1:0];
        sacvb_pkg::REG_VB_ENABLE:  vb_on = v[0];
        sacvb_pkg::REG_VB_ENTRIES: vb_count = v[3:0];
        default: ;
      endcase
    endfunction

    function int index_bits();
      int n;
      n = 0;
      if (c_log2 >= b_log2 + s_log2) n = c_log2 - b_log2 - s_log2;
      while (n > 8) n--;
      return n;
    endfunction

    function int way_count();
      return 1 << s_log2;
    endfunction

    function int num_vb();
      if (vb_count < 1) return 1;
      if (vb_count > 8) return 8;
      return vb_count;
    endfunction

    function int pick_victim(int base, int nw, int mru);
      int best;
      best = 0;
      if (policy == sacvb_pkg::POL_LFU) begin
        if (nw <= 1) return 0;
        best = (mru == 0) ? 1 : 0;
        for (int w = 0; w < nw; w++) begin
          if (w == mru) continue;
          if (line_uses[base+w] < line_uses[base+best] ||
              (line_uses[base+w] == line_uses[base+best] &&
               line_tag[base+w] > line_tag[base+best]))
            best = w;
        end
      end else if (policy == sacvb_pkg::POL_FIFO) begin
        for (int w = 1; w < nw; w++)
          if (line_born[base+w] < line_born[base+best]) best = w;
      end else begin
        for (int w = 1; w < nw; w++)
          if (line_last[base+w] < line_last[base+best]) best = w;
      end
      return best;
    endfunction

    function void fill(int ln, bit [47:0] tag, bit dirty);
      line_valid[ln] = 1;
      line_written[ln] = 1;
      line_tag[ln] = tag;
      line_dirty[ln] = dirty;
      line_uses[ln] = 0;
      line_last[ln] = stamp;
      line_born[ln] = stamp;
    endfunction

    // A victim hit under LFU compares tags of every way but the MRU one,
    // so it must not happen while such a way has never been filled.
    function bit risky(logic [47:0] addr);
      int ib, nw, set, base, mru;
      bit [47:0] baddr, tag;
      ib = index_bits();
      nw = way_count();
      baddr = addr >> b_log2;
      set = int'(baddr & ((48'd1 << ib) - 48'd1));
      tag = baddr >> ib;
      base = set * 8;
      mru = set_mru[set];
      for (int w = 0; w < nw; w++)
        if (line_valid[base+w] && line_tag[base+w] == tag) return 0;
      if (!vb_on || policy != sacvb_pkg::POL_LFU || nw <= 1) return 0;
      for (int e = 0; e < num_vb(); e++) begin
        if (vb_valid[e] && vb_addr[e] == baddr) begin
          for (int w = 0; w < nw; w++)
            if (w != mru && !line_written[base+w]) return 1;
          return 0;
        end
      end
      return 0;
    endfunction

    function void note_request(logic [47:0] addr, logic store);
      access_result_t r;
      int ib, nw, nv, set, base, mru, w, ln, slot;
      bit found, pd;
      bit [47:0] baddr, tag;
      r = '0;
      found = 0;
      stamp++;
      ib = index_bits();
      nw = way_count();
      nv = num_vb();
      baddr = addr >> b_log2;
      set = int'(baddr & ((48'd1 << ib) - 48'd1));
      tag = baddr >> ib;
      base = set * 8;
      mru = set_mru[set];
      for (w = 0; w < nw && !found; w++) begin
        ln = base + w;
        if (line_valid[ln] && line_tag[ln] == tag) begin
          found = 1;
          if (line_uses[ln] != 32'hFFFF_FFFF) line_uses[ln]++;
          line_last[ln] = stamp;
          if (store) line_dirty[ln] = 1;
          set_mru[set] = 3'(w);
          r.l1_hit = 1;
          r.way_used = 3'(w);
        end
      end
      if (!found && vb_on) begin
        for (int e = 0; e < nv && !found; e++) begin
          if (vb_valid[e] && vb_addr[e] == baddr) begin
            found = 1;
            pd = vb_dirty[e];
            w = pick_victim(base, nw, mru);
            ln = base + w;
            r.l1_evict = line_valid[ln];
            vb_addr[e] = (line_tag[ln] << ib) + 48'(set);
            vb_valid[e] = line_valid[ln];
            vb_dirty[e] = line_dirty[ln];
            vb_born[e] = stamp;
            fill(ln, tag, pd || store);
            set_mru[set] = 3'(w);
            r.vc_hit = 1;
            r.way_used = 3'(w);
          end
        end
      end
      if (!found) begin
        r.mem_fetch = 1;
        for (w = 0; w < nw && !found; w++)
          if (!line_valid[base+w]) begin
            found = 1;
            r.way_used = 3'(w);
          end
        if (!found) begin
          w = pick_victim(base, nw, mru);
          ln = base + w;
          r.l1_evict = 1;
          r.way_used = 3'(w);
          if (vb_on) begin
            slot = nv;
            for (int e = 0; e < nv; e++)
              if (!vb_valid[e]) begin
                slot = e;
                break;
              end
            if (slot == nv) begin
              slot = 0;
              for (int e = 1; e < nv; e++)
                if (vb_born[e] < vb_born[slot]) slot = e;
              if (vb_dirty[slot]) r.writeback = 1;
            end
            vb_addr[slot] = (line_tag[ln] << ib) + 48'(set);
            vb_valid[slot] = 1;
            vb_dirty[slot] = line_dirty[ln];
            vb_born[slot] = stamp;
          end else if (line_dirty[ln]) begin
            r.writeback = 1;
          end
        end
        fill(base + int'(r.way_used), tag, store);
        set_mru[set] = r.way_used;
      end
      if (r.l1_hit) l1_hits++;
      if (r.vc_hit) vb_hits++;
      if (r.writeback) wbacks++;
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_response(access_result_t got);
      access_result_t e;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected response %b", got));
        return;
      end
      e = expected_results.pop_front();
      checked++;
      if (got.l1_hit !== e.l1_hit) report($sformatf("l1_hit %b exp %b", got.l1_hit, e.l1_hit));
      if (got.vc_hit !== e.vc_hit) report($sformatf("vc_hit %b exp %b", got.vc_hit, e.vc_hit));
      if (got.l1_evict !== e.l1_evict)
        report($sformatf("l1_evict %b exp %b", got.l1_evict, e.l1_evict));
      if (got.writeback !== e.writeback)
        report($sformatf("writeback %b exp %b", got.writeback, e.writeback));
      if (got.mem_fetch !== e.mem_fetch)
        report($sformatf("mem_fetch %b exp %b", got.mem_fetch, e.mem_fetch));
      if (got.way_used !== e.way_used)
        report($sformatf("way_used %0d exp %0d", got.way_used, e.way_used));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [sacvb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sacvb_pkg::CFG_W-1:0] cfg_data = '0;
  bit calm = 0;
  cache_scoreboard sb = new();

  sacvb_req_if #(.ADDR_BITS(48)) req_ch ();
  sacvb_rsp_if rsp_ch ();

  set_assoc_cache_with_victim_buffer u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_ch), .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  initial begin
    req_ch.valid = 0;
    req_ch.addr = '0;
    req_ch.is_store = 0;
    rsp_ch.ready = 0;
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_response({rsp_ch.l1_hit, rsp_ch.vc_hit, rsp_ch.l1_evict, rsp_ch.writeback,
                         rsp_ch.mem_fetch, rsp_ch.way_used});
    rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 36);
  end

  task write_reg(logic [sacvb_pkg::CFG_IDX_W-1:0] idx, logic [sacvb_pkg::CFG_W-1:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task configure(int c, int b, int s, logic [1:0] pol, int ven, int vent);
    write_reg(sacvb_pkg::REG_CACHE_SIZE, 5'(c));
    write_reg(sacvb_pkg::REG_BLOCK_SIZE, 5'(b));
    write_reg(sacvb_pkg::REG_WAYS, 5'(s));
    write_reg(sacvb_pkg::REG_POLICY, 5'(pol));
    write_reg(sacvb_pkg::REG_VB_ENABLE, 5'(ven));
    write_reg(sacvb_pkg::REG_VB_ENTRIES, 5'(vent));
    cfg_we <= 0;
  endtask

  task send(logic [47:0] addr, logic store);
    if (!calm && $urandom_range(0, 99) < 36) begin
      req_ch.valid <= 0;
      @(posedge clk);
    end
    req_ch.addr <= addr;
    req_ch.is_store <= store;
    req_ch.valid <= 1;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    sb.note_request(addr, store);
  endtask

  task drain();
    req_ch.valid <= 0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function logic [47:0] build_addr(logic [47:0] tag, int set);
    int ib;
    logic [47:0] baddr, off;
    ib = sb.index_bits();
    baddr = (tag << ib) | 48'(set & ((1 << ib) - 1));
    off = {$urandom, $urandom} & ((48'd1 << sb.b_log2) - 48'd1);
    return (baddr << sb.b_log2) | off;
  endfunction

  function logic [47:0] random_addr();
    logic [47:0] a, tag;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      a = {$urandom, $urandom};
    end else begin
      tag = 48'($urandom_range(0, sb.way_count() + sb.num_vb() + 2));
      if (pick < 14) tag = ~tag;
      a = build_addr(tag, $urandom_range(0, 3));
    end
    while (sb.risky(a)) a = {$urandom, $urandom};
    return a;
  endfunction

  int cfg_c [NUM_PHASES] = '{12, 12, 10, 0, 23, 23, 8, 6, 14};
  int cfg_b [NUM_PHASES] = '{5, 5, 4, 0, 12, 0, 2, 3, 5};
  int cfg_s [NUM_PHASES] = '{2, 2, 3, 0, 3, 0, 1, 3, 1};
  logic [1:0] cfg_p [NUM_PHASES] =
    '{sacvb_pkg::POL_LRU, sacvb_pkg::POL_LFU, sacvb_pkg::POL_FIFO, sacvb_pkg::POL_LRU,
      sacvb_pkg::POL_LFU, POL_SPARE, sacvb_pkg::POL_LFU, sacvb_pkg::POL_FIFO,
      sacvb_pkg::POL_LFU};
  int cfg_ve [NUM_PHASES] = '{1, 1, 1, 1, 1, 0, 0, 1, 1};
  int cfg_vn [NUM_PHASES] = '{2, 4, 8, 1, 15, 0, 3, 0, 8};

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: fill one set, hit, store, evict dirty, a victim hit, extreme addresses.
    configure(12, 5, 2, sacvb_pkg::POL_LRU, 1, 2);
    for (int t = 0; t < 4; t++) send(build_addr(48'(t), 0), t[0]);
    send(build_addr(0, 0), 0);
    send(build_addr(1, 0), 1);
    send(build_addr(4, 0), 0);
    send(build_addr(5, 0), 1);
    send(build_addr(6, 0), 0);
    send(build_addr(2, 0), 0);
    send(build_addr(6, 0), 1);
    send(48'hFFFF_FFFF_FFFF, 1);
    send(48'hFFFF_FFFF_FFFF, 0);
    send(48'h0, 0);
    send(48'h0000_0000_001F, 1);
    send(48'hAAAA_AAAA_AAAA, 0);
    send(48'h5555_5555_5555, 1);
    drain();
    for (int p = 0; p < NUM_PHASES; p++) begin
      configure(cfg_c[p], cfg_b[p], cfg_s[p], cfg_p[p], cfg_ve[p], cfg_vn[p]);
      calm = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) send(random_addr(), 1'($urandom_range(0, 1)));
      drain();
      calm = 0;
    end
    $display("Checked %0d responses over %0d settings: %0d L1 hits, %0d victim hits, %0d writebacks.",
             sb.checked, NUM_PHASES + 1, sb.l1_hits, sb.vb_hits, sb.wbacks);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d responses outstanding.", sb.expected_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

[set_assoc_cache_with_victim_buffer.f]
rtl/core/sacvb_pkg.sv
rtl/core/sacvb_if.sv
rtl/core/sacvb_ctrl.sv
rtl/core/sacvb_dp.sv
rtl/core/set_assoc_cache_with_victim_buffer.sv
tb/tb.sv
